// ----- sv/qran_pkg.sv -----
// ----------------------------------------------------------------------------
// qran_pkg
// Shared types and constants of the alphanumeric data codeword encoder.
// ----------------------------------------------------------------------------
package qran_pkg;

    localparam int CMD_BITS_W = 19;
    localparam int BUF_W      = CMD_BITS_W + 7;

    localparam logic [3:0] MODE_ALNUM = 4'b0010;
    localparam int         ALNUM_BASE = 45;

    localparam logic [7:0] PAD_EVEN = 8'd236;
    localparam logic [7:0] PAD_ODD  = 8'd17;

    localparam logic [4:0] CAP_SMALL = 5'd16;
    localparam logic [4:0] CAP_LARGE = 5'd28;
    localparam logic [5:0] SMALL_MAX_LEN = 6'd20;
    localparam logic [5:0] MAX_LEN = 6'd38;
    localparam logic [4:0] MAX_BURST = 5'd16;

    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CW    = $clog2(OUTQ_DEPTH + 1);

    typedef struct packed {
        logic                  first;
        logic                  cap_large;
        logic                  err;
        logic                  close;
        logic [4:0]            nbits;
        logic [CMD_BITS_W-1:0] bits;
    } t_cmd;

    typedef struct packed {
        logic [7:0] codeword;
        logic       last;
        logic       err;
    } t_oword;

endpackage

// ----- sv/qr_alphanumeric_data_encoder_top.sv -----
// ----------------------------------------------------------------------------
// qr_alphanumeric_data_encoder_top: alphanumeric mode data codeword encoder
// A character can be taken every cycle while the command queue has room; the
// packer writes one codeword per cycle while the output queue has room; the
// bits of a character pass through the command queue and the packer's bit
// buffer into the output queue; a terminator and pad burst close the frame.
// Synchronous active-low reset empties both queues; no clearing pass.
// ----------------------------------------------------------------------------
module qr_alphanumeric_data_encoder_top import qran_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_character,
    input  logic [5:0] i_message_length,
    input  logic       i_last_char,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_codeword,
    output logic       o_last_codeword,
    output logic       o_error
);

    logic cmd_wr;
    t_cmd cmd_w;
    t_cmd cmd_r;
    logic cmd_rd;
    logic cmd_empty;

    qran_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (push),
        .i_character      (i_character),
        .i_message_length (i_message_length),
        .i_last_char      (i_last_char),
        .i_q_full         (full),
        .o_wr             (cmd_wr),
        .o_cmd            (cmd_w)
    );

    qran_cmd_queue u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (cmd_wr),
        .i_wdata (cmd_w),
        .o_full  (full),
        .i_rd    (cmd_rd),
        .o_rdata (cmd_r),
        .o_empty (cmd_empty)
    );

    qran_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_empty     (cmd_empty),
        .i_cmd           (cmd_r),
        .o_cmd_rd        (cmd_rd),
        .i_pop           (pop),
        .o_empty         (empty),
        .o_codeword      (o_codeword),
        .o_last_codeword (o_last_codeword),
        .o_error         (o_error)
    );

endmodule

// ----- sv/qran_front.sv -----
// ----------------------------------------------------------------------------
// qran_front
// Maps characters, pairs them and builds bit-field commands for the packer.
// ----------------------------------------------------------------------------
module qran_front import qran_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic [7:0] i_character,
    input  logic [5:0] i_message_length,
    input  logic       i_last_char,
    input  logic       i_q_full,
    output logic       o_wr,
    output t_cmd       o_cmd
);

    function automatic logic [6:0] map_char(input logic [7:0] c);
        logic [7:0] u;
        logic [6:0] r;
        begin
            u = (c inside {[8'h61:8'h7A]}) ? c - 8'd32 : c;
            if (u inside {[8'h30:8'h39]}) begin
                r = {1'b0, 6'(u - 8'h30)};
            end else if (u inside {[8'h41:8'h5A]}) begin
                r = {1'b0, 6'(u - 8'h41 + 8'd10)};
            end else begin
                case (u)
                    8'h20:   r = {1'b0, 6'd36};
                    8'h24:   r = {1'b0, 6'd37};
                    8'h25:   r = {1'b0, 6'd38};
                    8'h2A:   r = {1'b0, 6'd39};
                    8'h2B:   r = {1'b0, 6'd40};
                    8'h2D:   r = {1'b0, 6'd41};
                    8'h2E:   r = {1'b0, 6'd42};
                    8'h2F:   r = {1'b0, 6'd43};
                    8'h3A:   r = {1'b0, 6'd44};
                    default: r = {1'b1, 6'd0};
                endcase
            end
            return r;
        end
    endfunction

    logic        r_in_msg, n_in_msg;
    logic        r_err, n_err;
    logic        r_pend_v, n_pend_v;
    logic [5:0]  r_pend_val, n_pend_val;

    logic [6:0]  mapped;
    logic [5:0]  v;
    logic        first;
    logic        len_bad;
    logic        err;
    logic        pend_v;
    logic [10:0] pair;
    logic [12:0] hdr;
    logic        accept;

    assign accept  = i_push & ~i_q_full;
    assign mapped  = map_char(i_character);
    assign v       = mapped[5:0];
    assign first   = ~r_in_msg;
    assign len_bad = (i_message_length == 6'd0) | (i_message_length > MAX_LEN);
    assign err     = first ? (len_bad | mapped[6]) : (r_err | mapped[6]);
    assign pend_v  = first ? 1'b0 : r_pend_v;
    assign pair    = ({5'd0, r_pend_val} * 11'(ALNUM_BASE)) + {5'd0, v};
    assign hdr     = {MODE_ALNUM, 3'b000, i_message_length};

    always_comb begin
        o_wr            = accept;
        o_cmd.first     = first;
        o_cmd.cap_large = i_message_length > SMALL_MAX_LEN;
        o_cmd.err       = err;
        o_cmd.close     = i_last_char;
        if (first) begin
            if (i_last_char) begin
                o_cmd.bits  = {hdr, v};
                o_cmd.nbits = 5'd19;
            end else begin
                o_cmd.bits  = {hdr, 6'd0};
                o_cmd.nbits = 5'd13;
            end
        end else if (pend_v) begin
            o_cmd.bits  = {pair, 8'd0};
            o_cmd.nbits = 5'd11;
        end else if (i_last_char) begin
            o_cmd.bits  = {v, 13'd0};
            o_cmd.nbits = 5'd6;
        end else begin
            o_cmd.bits  = '0;
            o_cmd.nbits = 5'd0;
        end

        n_in_msg   = r_in_msg;
        n_err      = r_err;
        n_pend_v   = r_pend_v;
        n_pend_val = r_pend_val;
        if (accept) begin
            n_in_msg = ~i_last_char;
            n_err    = err;
            if (pend_v | i_last_char) begin
                n_pend_v = 1'b0;
            end else begin
                n_pend_v   = 1'b1;
                n_pend_val = v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_msg <= 1'b0;
            r_err    <= 1'b0;
            r_pend_v <= 1'b0;
        end else begin
            r_in_msg <= n_in_msg;
            r_err    <= n_err;
            r_pend_v <= n_pend_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_val <= n_pend_val;
    end

endmodule

// ----- sv/qran_cmd_queue.sv -----
// ----------------------------------------------------------------------------
// qran_cmd_queue
// Short command queue between the front end and the bit packer.
// ----------------------------------------------------------------------------
module qran_cmd_queue import qran_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_cmd i_wdata,
    output logic o_full,
    input  logic i_rd,
    output t_cmd o_rdata,
    output logic o_empty
);

    t_cmd               r_mem [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0] r_wp;
    logic [CMDQ_AW-1:0] r_rp;
    logic [CMDQ_CW-1:0] r_cnt;
    logic               do_wr;
    logic               do_rd;

    assign o_full  = r_cnt == CMDQ_CW'(CMDQ_DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_rdata = r_mem[r_rp];
    assign do_wr   = i_wr & ~o_full;
    assign do_rd   = i_rd & ~o_empty;

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_wr) begin
                r_wp <= r_wp + CMDQ_AW'(1);
            end
            if (do_rd) begin
                r_rp <= r_rp + CMDQ_AW'(1);
            end
            r_cnt <= r_cnt + CMDQ_CW'(do_wr) - CMDQ_CW'(do_rd);
        end
    end

endmodule

// ----- sv/qran_back.sv -----
// ----------------------------------------------------------------------------
// qran_back
// Bit packer: forms codewords, closes the frame with terminator and padding.
// ----------------------------------------------------------------------------
module qran_back import qran_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cmd_empty,
    input  t_cmd       i_cmd,
    output logic       o_cmd_rd,
    input  logic       i_pop,
    output logic       o_empty,
    output logic [7:0] o_codeword,
    output logic       o_last_codeword,
    output logic       o_error
);

    typedef enum logic [5:0] {
        S_LOAD  = 6'b000001,
        S_DATA  = 6'b000010,
        S_TERM  = 6'b000100,
        S_ALIGN = 6'b001000,
        S_PAD   = 6'b010000,
        S_FLUSH = 6'b100000
    } t_state;

    t_state             r_state, n_state;
    logic [BUF_W-1:0]   r_buf, n_buf;
    logic [4:0]         r_cnt, n_cnt;
    logic [4:0]         r_sent, n_sent;
    logic               r_cap_large, n_cap_large;
    logic               r_err, n_err;
    logic               r_close, n_close;
    logic [4:0]         r_nres, n_nres;
    logic               r_pad_odd, n_pad_odd;
    logic               r_hold_v, n_hold_v;
    logic [7:0]         r_hold, n_hold;
    logic               r_hold_err, n_hold_err;

    t_oword             r_oq [OUTQ_DEPTH];
    logic [OUTQ_AW-1:0] r_owp;
    logic [OUTQ_AW-1:0] r_orp;
    logic [OUTQ_CW-1:0] r_ocnt;
    logic               oq_wr;
    t_oword             oq_wdata;
    logic               oq_rd;
    logic               oq_full;

    logic [4:0]         cap;
    logic               full_frame;
    logic [4:0]         sent_inc;
    logic               full_inc;
    logic [4:0]         cnt_sub8;
    logic [4:0]         cnt_term;
    logic               emit;
    logic [7:0]         emit_byte;

    // load path
    logic [4:0]         ld_sent;
    logic               ld_cap_large;
    logic [BUF_W-1:0]   ld_buf;
    logic [4:0]         ld_cnt;
    logic               ld_full;
    logic [BUF_W-1:0]   ld_aligned;
    logic [4:0]         ld_cnt_app;

    assign cap        = r_cap_large ? CAP_LARGE : CAP_SMALL;
    assign full_frame = r_sent >= cap;
    assign sent_inc   = r_sent + 5'd1;
    assign full_inc   = sent_inc >= cap;
    assign cnt_sub8   = r_cnt - 5'd8;
    assign cnt_term   = ((cap - r_sent) == 5'd1 && r_cnt > 5'd4) ? 5'd8 : r_cnt + 5'd4;
    assign oq_full    = r_ocnt == OUTQ_CW'(OUTQ_DEPTH);

    assign ld_sent      = i_cmd.first ? 5'd0 : r_sent;
    assign ld_cap_large = i_cmd.first ? i_cmd.cap_large : r_cap_large;
    assign ld_buf       = i_cmd.first ? '0 : r_buf;
    assign ld_cnt       = i_cmd.first ? 5'd0 : r_cnt;
    assign ld_full      = ld_sent >= (ld_cap_large ? CAP_LARGE : CAP_SMALL);
    assign ld_aligned   = {i_cmd.bits, 7'd0} >> ld_cnt[2:0];
    assign ld_cnt_app   = ld_cnt + i_cmd.nbits;

    always_comb begin
        n_state     = r_state;
        n_buf       = r_buf;
        n_cnt       = r_cnt;
        n_sent      = r_sent;
        n_cap_large = r_cap_large;
        n_err       = r_err;
        n_close     = r_close;
        n_nres      = r_nres;
        n_pad_odd   = r_pad_odd;
        n_hold_v    = r_hold_v;
        n_hold      = r_hold;
        n_hold_err  = r_hold_err;
        o_cmd_rd    = 1'b0;
        emit        = 1'b0;
        emit_byte   = r_buf[BUF_W-1 -: 8];
        oq_wr       = 1'b0;
        oq_wdata    = '{codeword: r_hold, last: 1'b1, err: r_hold_err};

        case (r_state)
            S_LOAD: begin
                if (!i_cmd_empty) begin
                    o_cmd_rd    = 1'b1;
                    n_sent      = ld_sent;
                    n_cap_large = ld_cap_large;
                    n_err       = i_cmd.err;
                    n_close     = i_cmd.close;
                    n_nres      = 5'd0;
                    n_pad_odd   = 1'b0;
                    if (!ld_full) begin
                        n_buf = ld_buf | ld_aligned;
                        n_cnt = ld_cnt_app;
                    end else begin
                        n_buf = ld_buf;
                        n_cnt = ld_cnt;
                    end
                    if (!ld_full && ld_cnt_app >= 5'd8) begin
                        n_state = S_DATA;
                    end else if (i_cmd.close) begin
                        n_state = S_TERM;
                    end
                end
            end
            S_DATA: begin
                if (!oq_full) begin
                    emit   = 1'b1;
                    n_sent = sent_inc;
                    if (full_inc) begin
                        n_buf = '0;
                        n_cnt = 5'd0;
                    end else begin
                        n_buf = r_buf << 8;
                        n_cnt = cnt_sub8;
                    end
                    if (!full_inc && cnt_sub8 >= 5'd8) begin
                        n_state = S_DATA;
                    end else if (r_close) begin
                        n_state = S_TERM;
                    end else begin
                        n_state = S_LOAD;
                    end
                end
            end
            S_TERM: begin
                if (full_frame) begin
                    n_state = S_FLUSH;
                end else if (cnt_term >= 5'd8) begin
                    if (!oq_full) begin
                        emit    = 1'b1;
                        n_sent  = sent_inc;
                        n_state = S_ALIGN;
                        if (full_inc) begin
                            n_buf = '0;
                            n_cnt = 5'd0;
                        end else begin
                            n_buf = r_buf << 8;
                            n_cnt = cnt_term - 5'd8;
                        end
                    end
                end else begin
                    n_cnt   = cnt_term;
                    n_state = S_ALIGN;
                end
            end
            S_ALIGN: begin
                if (!full_frame && r_cnt != 5'd0) begin
                    if (!oq_full) begin
                        emit    = 1'b1;
                        n_sent  = sent_inc;
                        n_buf   = '0;
                        n_cnt   = 5'd0;
                        n_state = S_PAD;
                    end
                end else begin
                    n_buf   = '0;
                    n_cnt   = 5'd0;
                    n_state = S_PAD;
                end
            end
            S_PAD: begin
                if (!full_frame && r_nres < MAX_BURST) begin
                    if (!oq_full) begin
                        emit      = 1'b1;
                        emit_byte = r_pad_odd ? PAD_ODD : PAD_EVEN;
                        n_sent    = sent_inc;
                        n_pad_odd = ~r_pad_odd;
                    end
                end else begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                n_buf = '0;
                n_cnt = 5'd0;
                if (r_hold_v) begin
                    if (!oq_full) begin
                        oq_wr    = 1'b1;
                        n_hold_v = 1'b0;
                        n_state  = S_LOAD;
                    end
                end else begin
                    n_state = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase

        // closing words go through the hold stage so the final one gets its flag
        if (emit) begin
            n_nres = r_nres + 5'd1;
            if (r_close) begin
                if (r_hold_v) begin
                    oq_wr    = 1'b1;
                    oq_wdata = '{codeword: r_hold, last: 1'b0, err: r_hold_err};
                end
                n_hold_v   = 1'b1;
                n_hold     = emit_byte;
                n_hold_err = r_err;
            end else begin
                oq_wr    = 1'b1;
                oq_wdata = '{codeword: emit_byte, last: full_inc, err: r_err};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_cnt       <= 5'd0;
            r_sent      <= 5'd0;
            r_cap_large <= 1'b0;
            r_close     <= 1'b0;
            r_nres      <= 5'd0;
            r_pad_odd   <= 1'b0;
            r_hold_v    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_sent      <= n_sent;
            r_cap_large <= n_cap_large;
            r_close     <= n_close;
            r_nres      <= n_nres;
            r_pad_odd   <= n_pad_odd;
            r_hold_v    <= n_hold_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf <= '0;
        end else begin
            r_buf <= n_buf;
        end
    end

    always_ff @(posedge i_clk) begin
        r_err      <= n_err;
        r_hold     <= n_hold;
        r_hold_err <= n_hold_err;
    end

    // output word queue
    assign oq_rd           = i_pop & ~o_empty;
    assign o_empty         = r_ocnt == '0;
    assign o_codeword      = r_oq[r_orp].codeword;
    assign o_last_codeword = r_oq[r_orp].last;
    assign o_error         = r_oq[r_orp].err;

    always_ff @(posedge i_clk) begin
        if (oq_wr) begin
            r_oq[r_owp] <= oq_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owp  <= '0;
            r_orp  <= '0;
            r_ocnt <= '0;
        end else begin
            if (oq_wr) begin
                r_owp <= r_owp + OUTQ_AW'(1);
            end
            if (oq_rd) begin
                r_orp <= r_orp + OUTQ_AW'(1);
            end
            r_ocnt <= r_ocnt + OUTQ_CW'(oq_wr) - OUTQ_CW'(oq_rd);
        end
    end

endmodule
